>>> hw/rtl/fgwr_pkg.sv
// shared types, constants and letter helpers for the free group word reducer
package fgwr_pkg;

    localparam int LETTER_W    = 7;
    localparam int POS_W       = 8;
    localparam int LENGTH_W    = 9;

    // case swap and inverse test on ascii codes
    localparam int CASE_LIMIT  = 96;
    localparam int CASE_DELTA  = 32;
    localparam int CASE_PERIOD = 64;
    localparam int MOD_W       = $clog2(CASE_PERIOD);

    typedef logic [LETTER_W-1:0] letter_t;

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_CYCLIC = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    // other case of a letter, kept to the letter width
    function automatic letter_t swap_case(letter_t c);
        letter_t r;
        if (c > LETTER_W'(CASE_LIMIT))
            r = c - LETTER_W'(CASE_DELTA);
        else
            r = c + LETTER_W'(CASE_DELTA);
        return r;
    endfunction

    // a and b cancel when a - b + delta is a multiple of the period
    function automatic logic is_inverse(letter_t a, letter_t b);
        logic [MOD_W-1:0] d;
        d = a[MOD_W-1:0] - b[MOD_W-1:0] + MOD_W'(CASE_DELTA);
        return (d == '0);
    endfunction

endpackage

>>> hw/rtl/fgwr_stack.sv
// letter stack memory: one write port, two registered read ports
module fgwr_stack #(
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  fgwr_pkg::letter_t    wr_data,
    input  logic [AW-1:0]        rd_a_addr,
    output fgwr_pkg::letter_t    rd_a_data,
    input  logic [AW-1:0]        rd_b_addr,
    output fgwr_pkg::letter_t    rd_b_data
);

    fgwr_pkg::letter_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

>>> hw/rtl/free_group_word_reducer_core.sv
// free group word reducer: letter stack with free and cyclic reduction
// flow: append passes S_APPEND and an in-range read S_READ before S_EMIT loads the result word;
//   clear, a bad-position read and a cyclic reduce of a word under two letters go straight to S_EMIT
// cyclic reduce: S_CYCLIC strips pairs until stripping empties the word or leaves one letter, or until
//   a mismatched pair stops it; a new word is taken only in S_IDLE, once the result is registered
// reset: word empty (top and start at zero); stack contents undefined, never used unwritten
module free_group_word_reducer_core #(
    parameter int MAX_LETTERS = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,

    // input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         func,
    input  logic [fgwr_pkg::LETTER_W-1:0]      letter,
    input  logic [fgwr_pkg::POS_W-1:0]         position,
    input  logic                               read_inverse,

    // output channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [fgwr_pkg::LENGTH_W-1:0]      word_length,
    output logic [fgwr_pkg::LETTER_W-1:0]      letter_out,
    output logic                               cancelled,
    output logic                               overflow,
    output logic                               bad_position
);

    // address width of the stack and count width (count reaches MAX_LETTERS)
    localparam int AW = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
    localparam int CW = $clog2(MAX_LETTERS + 1);
    // width wide enough for length compares against the position and small constants
    localparam int LW = (CW > fgwr_pkg::POS_W) ? CW : fgwr_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_CYCLIC,
        S_READ,
        S_EMIT
    } state_t;

    state_t                 state_reg, state_next;

    // word bounds: the word sits in entries start .. top-1
    logic [CW-1:0]          top_reg, top_next;
    logic [AW-1:0]          start_reg, start_next;

    // command held while the memory read is in flight
    fgwr_pkg::letter_t      cmd_letter_reg, cmd_letter_next;
    logic                   cmd_inv_reg, cmd_inv_next;

    // result waiting for the output register
    fgwr_pkg::letter_t      res_letter_reg, res_letter_next;
    logic                   res_cancel_reg, res_cancel_next;
    logic                   res_over_reg, res_over_next;
    logic                   res_bad_reg, res_bad_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [fgwr_pkg::LENGTH_W-1:0] out_length_reg, out_length_next;
    fgwr_pkg::letter_t      out_letter_reg, out_letter_next;
    logic                   out_cancel_reg, out_cancel_next;
    logic                   out_over_reg, out_over_next;
    logic                   out_bad_reg, out_bad_next;

    // memory ports
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    fgwr_pkg::letter_t      wr_data;
    logic [AW-1:0]          rd_a_addr;
    logic [AW-1:0]          rd_b_addr;
    fgwr_pkg::letter_t      rd_a_data;
    fgwr_pkg::letter_t      rd_b_data;

    // derived word quantities
    logic [CW-1:0]          len;
    logic [LW-1:0]          len_w;
    logic [LW-1:0]          pos_w;
    logic                   pos_bad;
    logic [AW-1:0]          top_last_addr;
    logic [AW-1:0]          read_addr;
    logic                   slot_free;

    fgwr_stack #(
        .DEPTH (MAX_LETTERS)
    ) u_stack (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (rd_a_data),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (rd_b_data)
    );

    assign len           = top_reg - CW'(start_reg);
    assign len_w         = LW'(len);
    assign pos_w         = LW'(position);
    assign pos_bad       = (pos_w >= len_w);
    assign top_last_addr = AW'(top_reg - CW'(1));

    // read target: forward from start, or backward from the top for the inverse word
    assign read_addr = read_inverse ? AW'(top_reg - CW'(1) - CW'(position))
                                    : AW'(CW'(start_reg) + CW'(position));

    // output register can take a new word this cycle
    assign slot_free = !out_valid_reg || out_ready;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        top_next        = top_reg;
        start_next      = start_reg;
        cmd_letter_next = cmd_letter_reg;
        cmd_inv_next    = cmd_inv_reg;
        res_letter_next = res_letter_reg;
        res_cancel_next = res_cancel_reg;
        res_over_next   = res_over_reg;
        res_bad_next    = res_bad_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        out_length_next = out_length_reg;
        out_letter_next = out_letter_reg;
        out_cancel_next = out_cancel_reg;
        out_over_next   = out_over_reg;
        out_bad_next    = out_bad_reg;

        wr_en     = 1'b0;
        wr_addr   = top_reg[AW-1:0];
        wr_data   = cmd_letter_reg;
        rd_a_addr = top_last_addr;
        rd_b_addr = top_last_addr;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_letter_next = letter;
                    cmd_inv_next    = read_inverse;
                    res_letter_next = '0;
                    res_cancel_next = 1'b0;
                    res_over_next   = 1'b0;
                    res_bad_next    = 1'b0;
                    case (fgwr_pkg::func_t'(func))
                        fgwr_pkg::FUNC_APPEND:
                        begin
                            // fetch the top letter; ignored when the word is empty
                            rd_a_addr  = top_last_addr;
                            state_next = S_APPEND;
                        end
                        fgwr_pkg::FUNC_CYCLIC:
                        begin
                            if (len_w >= LW'(2))
                            begin
                                rd_a_addr  = start_reg;
                                rd_b_addr  = top_last_addr;
                                state_next = S_CYCLIC;
                            end
                            else
                            begin
                                state_next = S_EMIT;
                            end
                        end
                        fgwr_pkg::FUNC_READ:
                        begin
                            if (pos_bad)
                            begin
                                res_bad_next = 1'b1;
                                state_next   = S_EMIT;
                            end
                            else
                            begin
                                rd_a_addr  = read_addr;
                                state_next = S_READ;
                            end
                        end
                        fgwr_pkg::FUNC_CLEAR:
                        begin
                            top_next   = '0;
                            start_next = '0;
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            S_APPEND:
            begin
                if ((len != '0) && fgwr_pkg::is_inverse(rd_a_data, cmd_letter_reg))
                begin
                    // cancel against the top; an emptied word returns to the base
                    res_cancel_next = 1'b1;
                    if (len == CW'(1))
                    begin
                        top_next   = '0;
                        start_next = '0;
                    end
                    else
                    begin
                        top_next = top_reg - CW'(1);
                    end
                end
                else if (top_reg == CW'(MAX_LETTERS))
                begin
                    res_over_next = 1'b1;
                end
                else
                begin
                    // push; the next command reads only after S_EMIT, so the write has landed
                    wr_en    = 1'b1;
                    top_next = top_reg + CW'(1);
                end
                state_next = S_EMIT;
            end

            S_CYCLIC:
            begin
                // first letter on port a, last letter on port b
                if (rd_a_data == fgwr_pkg::swap_case(rd_b_data))
                begin
                    if (len_w == LW'(2))
                    begin
                        top_next   = '0;
                        start_next = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        top_next   = top_reg - CW'(1);
                        start_next = AW'(CW'(start_reg) + CW'(1));
                        if (len_w >= LW'(4))
                        begin
                            // next pair inward, no write pending so no hazard
                            rd_a_addr = AW'(CW'(start_reg) + CW'(1));
                            rd_b_addr = AW'(top_reg - CW'(2));
                        end
                        else
                        begin
                            state_next = S_EMIT;
                        end
                    end
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_READ:
            begin
                res_letter_next = cmd_inv_reg ? fgwr_pkg::swap_case(rd_a_data) : rd_a_data;
                state_next      = S_EMIT;
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_length_next = fgwr_pkg::LENGTH_W'(len);
                    out_letter_next = res_letter_reg;
                    out_cancel_next = res_cancel_reg;
                    out_over_next   = res_over_reg;
                    out_bad_next    = res_bad_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            top_reg        <= '0;
            start_reg      <= '0;
            cmd_letter_reg <= '0;
            cmd_inv_reg    <= 1'b0;
            res_letter_reg <= '0;
            res_cancel_reg <= 1'b0;
            res_over_reg   <= 1'b0;
            res_bad_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_length_reg <= '0;
            out_letter_reg <= '0;
            out_cancel_reg <= 1'b0;
            out_over_reg   <= 1'b0;
            out_bad_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            top_reg        <= top_next;
            start_reg      <= start_next;
            cmd_letter_reg <= cmd_letter_next;
            cmd_inv_reg    <= cmd_inv_next;
            res_letter_reg <= res_letter_next;
            res_cancel_reg <= res_cancel_next;
            res_over_reg   <= res_over_next;
            res_bad_reg    <= res_bad_next;
            out_valid_reg  <= out_valid_next;
            out_length_reg <= out_length_next;
            out_letter_reg <= out_letter_next;
            out_cancel_reg <= out_cancel_next;
            out_over_reg   <= out_over_next;
            out_bad_reg    <= out_bad_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign word_length  = out_length_reg;
    assign letter_out   = out_letter_reg;
    assign cancelled    = out_cancel_reg;
    assign overflow     = out_over_reg;
    assign bad_position = out_bad_reg;

endmodule

>>> verif/testbench.sv
// self-checking testbench for the free group word reducer: scoreboard, directed and random traffic
`timescale 1ns / 100ps

module testbench;

    localparam int STACK_DEPTH  = 256;
    localparam int RANDOM_WORDS = 1700;
    localparam int TAIL_CYCLES  = 300;
    localparam int LONG_HOLD    = 200;   // receiver hold-off that backs up the input side

    localparam fgwr_pkg::letter_t UPPER_A = 7'h41;
    localparam fgwr_pkg::letter_t LOWER_A = 7'h61;

    typedef struct packed {
        logic [fgwr_pkg::LENGTH_W-1:0] length;
        fgwr_pkg::letter_t             letter;
        logic                          cancelled;
        logic                          overflow;
        logic                          bad_position;
    } reduce_result_t;

    // mirrors the letter stack and keeps the results still owed by the block
    class word_scoreboard;
        fgwr_pkg::letter_t letters[STACK_DEPTH];
        int                top_count;
        int                first_index;
        reduce_result_t    expected_results[$];
        int                errors;
        int                checked;
        int                cancel_count;
        int                overflow_count;
        int                bad_read_count;
        int                pairs_removed;

        function new();
            top_count      = 0;
            first_index    = 0;
            errors         = 0;
            checked        = 0;
            cancel_count   = 0;
            overflow_count = 0;
            bad_read_count = 0;
            pairs_removed  = 0;
        endfunction

        function int length();
            return top_count - first_index;
        endfunction

        function fgwr_pkg::letter_t last_letter();
            return (length() > 0) ? letters[top_count - 1] : '0;
        endfunction

        // other case, wrapping at 7 bits
        static function fgwr_pkg::letter_t flip_case(fgwr_pkg::letter_t c);
            int v;
            v = (c > fgwr_pkg::CASE_LIMIT) ? int'(c) - fgwr_pkg::CASE_DELTA
                                           : int'(c) + fgwr_pkg::CASE_DELTA;
            return fgwr_pkg::letter_t'(v);
        endfunction

        // code distance of 32 or 96 in either direction
        static function bit cancels(fgwr_pkg::letter_t top, fgwr_pkg::letter_t incoming);
            int diff;
            diff = int'(top) - int'(incoming);
            return ((diff + fgwr_pkg::CASE_DELTA) % fgwr_pkg::CASE_PERIOD) == 0;
        endfunction

        function void apply_command(fgwr_pkg::func_t op, fgwr_pkg::letter_t ltr,
                                    logic [fgwr_pkg::POS_W-1:0] pos, logic inv);
            reduce_result_t r;
            r = '0;
            case (op)
                fgwr_pkg::FUNC_APPEND: begin
                    if (length() > 0 && cancels(letters[top_count - 1], ltr)) begin
                        top_count--;
                        r.cancelled = 1'b1;
                        if (top_count <= first_index) begin
                            top_count   = 0;
                            first_index = 0;
                        end
                    end
                    else if (top_count >= STACK_DEPTH)
                        r.overflow = 1'b1;
                    else begin
                        letters[top_count] = ltr;
                        top_count++;
                    end
                end
                fgwr_pkg::FUNC_CYCLIC: begin
                    while (length() >= 2 &&
                           letters[first_index] == flip_case(letters[top_count - 1])) begin
                        first_index++;
                        top_count--;
                        pairs_removed++;
                    end
                    if (length() == 0) begin
                        top_count   = 0;
                        first_index = 0;
                    end
                end
                fgwr_pkg::FUNC_READ: begin
                    if (int'(pos) >= length())
                        r.bad_position = 1'b1;
                    else if (inv)
                        r.letter = flip_case(letters[top_count - 1 - int'(pos)]);
                    else
                        r.letter = letters[first_index + int'(pos)];
                end
                default: begin
                    top_count   = 0;
                    first_index = 0;
                end
            endcase
            r.length = fgwr_pkg::LENGTH_W'(length());
            cancel_count   += r.cancelled;
            overflow_count += r.overflow;
            bad_read_count += r.bad_position;
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [fgwr_pkg::LENGTH_W-1:0] want,
                                    logic [fgwr_pkg::LENGTH_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(reduce_result_t got);
            reduce_result_t want;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual length %0d",
                         $time, got.length);
                return;
            end
            want = expected_results.pop_front();
            checked++;
            compare_field("word_length", want.length, got.length);
            compare_field("letter_out", want.letter, got.letter);
            compare_field("cancelled", want.cancelled, got.cancelled);
            compare_field("overflow", want.overflow, got.overflow);
            compare_field("bad_position", want.bad_position, got.bad_position);
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [1:0]                    func;
    fgwr_pkg::letter_t             letter;
    logic [fgwr_pkg::POS_W-1:0]    position;
    logic                          read_inverse;
    logic                          out_valid;
    logic                          out_ready;
    logic [fgwr_pkg::LENGTH_W-1:0] word_length;
    fgwr_pkg::letter_t             letter_out;
    logic                          cancelled;
    logic                          overflow;
    logic                          bad_position;

    word_scoreboard board = new();
    bit             gapless;       // sender in a stretch with no idle cycles
    bit             out_gapless;   // receiver likewise
    int             words_sent;
    int             results_seen;

    free_group_word_reducer_core #(
        .MAX_LETTERS (STACK_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .letter       (letter),
        .position     (position),
        .read_inverse (read_inverse),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .word_length  (word_length),
        .letter_out   (letter_out),
        .cancelled    (cancelled),
        .overflow     (overflow),
        .bad_position (bad_position)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(fgwr_pkg::func_t op, fgwr_pkg::letter_t ltr,
                             logic [fgwr_pkg::POS_W-1:0] pos, logic inv);
        int gap;
        gap = gapless ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        func         <= op;
        letter       <= ltr;
        position     <= pos;
        read_inverse <= inv;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.apply_command(op, ltr, pos, inv);
        words_sent++;
        @(negedge clk);
    endtask

    // sender stays quiet until every owed result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (board.expected_results.size() != 0);
    endtask

    function automatic fgwr_pkg::letter_t alpha_letter(int span);
        fgwr_pkg::letter_t base;
        base = $urandom_range(0, 1) ? LOWER_A : UPPER_A;
        return base + fgwr_pkg::letter_t'($urandom_range(0, span));
    endfunction

    // span 0 means any 7-bit code, otherwise letters from an alphabet of span + 1 codes in each case
    function automatic fgwr_pkg::letter_t fresh_letter(fgwr_pkg::letter_t prev, int span);
        fgwr_pkg::letter_t c;
        do
            c = (span == 0) ? fgwr_pkg::letter_t'($urandom_range(0, 127)) : alpha_letter(span);
        while (word_scoreboard::cancels(prev, c));
        return c;
    endfunction

    task automatic send_read(bit in_range);
        int len;
        len = board.length();
        if (in_range && len > 0)
            send_word(fgwr_pkg::FUNC_READ, '0, fgwr_pkg::POS_W'($urandom_range(0, len - 1)),
                      1'($urandom_range(0, 1)));
        else
            send_word(fgwr_pkg::FUNC_READ, '0, fgwr_pkg::POS_W'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic directed_words();
        send_word(fgwr_pkg::FUNC_READ, '0, '0, 1'b0);           // read of the empty word
        send_word(fgwr_pkg::FUNC_CYCLIC, '0, '0, 1'b0);         // cyclic reduce of the empty word
        send_word(fgwr_pkg::FUNC_APPEND, LOWER_A, '0, 1'b0);
        send_word(fgwr_pkg::FUNC_CYCLIC, '0, '0, 1'b0);         // single letter, nothing to strip
        send_word(fgwr_pkg::FUNC_READ, '0, '0, 1'b0);
        send_word(fgwr_pkg::FUNC_READ, '0, '0, 1'b1);
        send_word(fgwr_pkg::FUNC_READ, '0, 8'd1, 1'b0);         // one past the end
        send_word(fgwr_pkg::FUNC_APPEND, UPPER_A, '0, 1'b0);    // a then A cancels to empty
        send_word(fgwr_pkg::FUNC_APPEND, 7'd0, '0, 1'b0);
        send_word(fgwr_pkg::FUNC_APPEND, 7'd96, '0, 1'b0);      // non-letters 96 apart
        send_word(fgwr_pkg::FUNC_APPEND, 7'd127, '0, 1'b0);
        send_word(fgwr_pkg::FUNC_APPEND, 7'd31, '0, 1'b0);
        send_word(fgwr_pkg::FUNC_APPEND, 7'd96, '0, 1'b0);
        send_word(fgwr_pkg::FUNC_READ, '0, '0, 1'b1);           // case swap of 96 wraps to zero
        send_word(fgwr_pkg::FUNC_CLEAR, 7'd127, 8'd255, 1'b1);
        send_word(fgwr_pkg::FUNC_APPEND, LOWER_A, '0, 1'b0);
        send_word(fgwr_pkg::FUNC_APPEND, LOWER_A + 7'd1, '0, 1'b0);
        send_word(fgwr_pkg::FUNC_APPEND, LOWER_A + 7'd2, '0, 1'b0);
        send_word(fgwr_pkg::FUNC_APPEND, UPPER_A, '0, 1'b0);
        send_word(fgwr_pkg::FUNC_CYCLIC, '0, '0, 1'b0);         // strips a ... A, word leaves index 0
        send_word(fgwr_pkg::FUNC_READ, '0, 8'd1, 1'b0);
        send_word(fgwr_pkg::FUNC_READ, '0, 8'd0, 1'b1);
        send_word(fgwr_pkg::FUNC_APPEND, UPPER_A + 7'd2, '0, 1'b0);
        send_word(fgwr_pkg::FUNC_APPEND, UPPER_A + 7'd1, '0, 1'b0);  // offset word cancels away
        send_word(fgwr_pkg::FUNC_READ, '0, 8'd255, 1'b1);
    endtask

    // full stack: overflow, cancel at full, cyclic strip, overflow with the word off index 0
    task automatic fill_stack();
        fgwr_pkg::letter_t first;
        fgwr_pkg::letter_t prev;
        fgwr_pkg::letter_t c;
        send_word(fgwr_pkg::FUNC_CLEAR, '0, '0, 1'b0);
        first = alpha_letter(25);
        send_word(fgwr_pkg::FUNC_APPEND, first, '0, 1'b0);
        prev = first;
        for (int i = 1; i < STACK_DEPTH - 1; i++)
        begin
            do
                c = fresh_letter(prev, 0);
            while (i == STACK_DEPTH - 2 &&
                   word_scoreboard::cancels(c, word_scoreboard::flip_case(first)));
            send_word(fgwr_pkg::FUNC_APPEND, c, '0, 1'b0);
            prev = c;
        end
        prev = word_scoreboard::flip_case(first);
        send_word(fgwr_pkg::FUNC_APPEND, prev, '0, 1'b0);
        repeat (2) send_word(fgwr_pkg::FUNC_APPEND, fresh_letter(prev, 0), '0, 1'b0);
        send_word(fgwr_pkg::FUNC_READ, '0, 8'd0, 1'b0);
        send_word(fgwr_pkg::FUNC_READ, '0, 8'd255, 1'b0);
        send_word(fgwr_pkg::FUNC_READ, '0, 8'd255, 1'b1);
        send_read(1'b1);
        send_word(fgwr_pkg::FUNC_APPEND, word_scoreboard::flip_case(prev), '0, 1'b0);
        send_word(fgwr_pkg::FUNC_APPEND, prev, '0, 1'b0);
        send_word(fgwr_pkg::FUNC_CYCLIC, '0, '0, 1'b0);
        c = fresh_letter(board.last_letter(), 0);
        send_word(fgwr_pkg::FUNC_APPEND, c, '0, 1'b0);
        send_word(fgwr_pkg::FUNC_APPEND, fresh_letter(c, 0), '0, 1'b0);
        send_word(fgwr_pkg::FUNC_READ, '0, 8'd254, 1'b1);
        send_word(fgwr_pkg::FUNC_READ, '0, 8'd255, 1'b0);
        send_word(fgwr_pkg::FUNC_CLEAR, '0, '0, 1'b0);
    endtask

    // small alphabet so appends cancel often and the length random-walks
    task automatic cancel_run();
        int roll;
        repeat ($urandom_range(8, 40))
        begin
            roll = $urandom_range(0, 19);
            if (roll < 15)
                send_word(fgwr_pkg::FUNC_APPEND, alpha_letter(2), '0, 1'b0);
            else if (roll < 18)
                send_read(1'b1);
            else if (roll < 19)
                send_read(1'b0);
            else
                send_word(fgwr_pkg::FUNC_CYCLIC, '0, '0, 1'b0);
        end
    endtask

    // u core u^-1 so the cyclic reduce has pairs to strip
    task automatic cyclic_run();
        fgwr_pkg::letter_t half[$];
        fgwr_pkg::letter_t prev;
        fgwr_pkg::letter_t c;
        if ($urandom_range(0, 9) < 7)
            send_word(fgwr_pkg::FUNC_CLEAR, '0, '0, 1'b0);
        prev = board.last_letter();
        repeat ($urandom_range(1, 6))
        begin
            c = fresh_letter(prev, 25);
            send_word(fgwr_pkg::FUNC_APPEND, c, '0, 1'b0);
            half.push_back(c);
            prev = c;
        end
        repeat ($urandom_range(1, 3))
        begin
            do
                c = fresh_letter(prev, 25);
            while (word_scoreboard::cancels(c, word_scoreboard::flip_case(half[$])));
            send_word(fgwr_pkg::FUNC_APPEND, c, '0, 1'b0);
            prev = c;
        end
        while (half.size() > 0)
            send_word(fgwr_pkg::FUNC_APPEND, word_scoreboard::flip_case(half.pop_back()),
                      '0, 1'b0);
        send_word(fgwr_pkg::FUNC_CYCLIC, '0, '0, 1'b0);
        repeat ($urandom_range(1, 4)) send_read(1'b1);
    endtask

    task automatic noise_run();
        repeat ($urandom_range(3, 10))
            send_word(fgwr_pkg::func_t'($urandom_range(0, 3)),
                      fgwr_pkg::letter_t'($urandom_range(0, 127)),
                      fgwr_pkg::POS_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin : stimulus
        int  start_count;
        int  kind;
        bit  drained_midway;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = fgwr_pkg::FUNC_APPEND;
        letter       = '0;
        position     = '0;
        read_inverse = 1'b0;
        gapless      = 1'b0;
        words_sent   = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_words();
        wait_drained();
        fill_stack();

        start_count    = words_sent;
        drained_midway = 1'b0;
        while (words_sent - start_count < RANDOM_WORDS)
        begin
            gapless = ($urandom_range(0, 3) == 0);
            kind    = $urandom_range(0, 19);
            if (kind < 9)
                cancel_run();
            else if (kind < 16)
                cyclic_run();
            else
                noise_run();
            if (!drained_midway && words_sent - start_count >= RANDOM_WORDS / 2)
            begin
                wait_drained();
                drained_midway = 1'b1;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("checked %0d results from %0d words: %0d cancels, %0d overflows",
                 board.checked, words_sent, board.cancel_count, board.overflow_count);
        $display("%0d out-of-range reads, %0d letter pairs stripped by cyclic reduce",
                 board.bad_read_count, board.pairs_removed);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : result_sink
        int             stall;
        reduce_result_t got;
        out_ready    = 1'b0;
        out_gapless  = 1'b0;
        results_seen = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (results_seen % 50 == 0)
                out_gapless = ($urandom_range(0, 3) == 0);
            // long hold-offs let the block fill up and push back on the sender
            if (results_seen == 300 || results_seen == 1300)
                stall = LONG_HOLD;
            else
                stall = out_gapless ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            got.length       = word_length;
            got.letter       = letter_out;
            got.cancelled    = cancelled;
            got.overflow     = overflow;
            got.bad_position = bad_position;
            board.check_result(got);
            results_seen++;
            @(negedge clk);
        end
    end

endmodule

>>> sim.f
hw/rtl/fgwr_pkg.sv
hw/rtl/fgwr_stack.sv
hw/rtl/free_group_word_reducer_core.sv
verif/testbench.sv
